FILE: rtl/twsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twsa_pkg
// Shared widths, register indexes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package twsa_pkg;

  localparam int WINDOW     = 100;
  localparam int TEMP_W     = 16;
  localparam int HUM_W      = 14;
  localparam int CNT_W      = 32;
  localparam int FILL_OUT_W = 7;
  localparam int SLOT_W     = $clog2(WINDOW);
  localparam int FILL_W     = $clog2(WINDOW + 1);
  localparam int WSUM_W     = TEMP_W + $clog2(WINDOW) + 1;
  localparam int DIV_W      = 48;
  localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 136;
  localparam int OUT_USER_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_TEMP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_TEMP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HUMIDITY  = 2'd2;

  localparam logic DIV_SEL_MEAN = 1'b0;
  localparam logic DIV_SEL_WIN  = 1'b1;

  localparam logic signed [TEMP_W-1:0] TEMP_MAX   = 16'sh7FFF;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN   = 16'sh8000;
  localparam logic signed [TEMP_W-1:0] HIGH_RESET = 16'sd2800;
  localparam logic signed [TEMP_W-1:0] LOW_RESET  = 16'sd1500;
  localparam logic [HUM_W-1:0]         HUM_RESET  = 14'd8000;
  localparam logic [CNT_W-1:0]         CNT_SAT    = '1;

  typedef struct packed {
    logic capture;
    logic update;
    logic div_start;
    logic div_sel;
    logic store_mean;
    logic store_mavg;
    logic load_out;
  } twsa_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } twsa_sts_t;

endpackage

FILE: rtl/twsa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module twsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 100
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/twsa_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twsa_div
// Restoring divider, one quotient bit per cycle. Signed dividend, positive
// divisor, quotient truncated toward zero; low 16 quotient bits returned.
// ----------------------------------------------------------------------------
module twsa_div
  import twsa_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [DIV_W-1:0]  dividend,
  input  logic [CNT_W-1:0]         divisor,
  output logic                     busy,
  output logic signed [TEMP_W-1:0] quotient
);

  logic [DIV_W-1:0]     quo_r;
  logic [CNT_W-1:0]     rem_r;
  logic [CNT_W-1:0]     dsr_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 neg_r;
  logic [CNT_W:0]       trial;
  logic                 fits;
  logic [TEMP_W-1:0]    q_lo;

  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign fits  = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_CNT_W'(DIV_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);
      rem_r <= '0;
      dsr_r <= divisor;
      neg_r <= dividend[DIV_W-1];
    end else if (busy_r) begin
      rem_r <= fits ? CNT_W'(trial - {1'b0, dsr_r}) : trial[CNT_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], fits};
    end
  end

  assign q_lo     = quo_r[TEMP_W-1:0];
  assign busy     = busy_r;
  assign quotient = neg_r ? $signed(-q_lo) : $signed(q_lo);

  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0)
    else $error("divider busy with zero step count");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider restarted while busy");

  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && cnt_r == DIV_CNT_W'(DIV_W))
    else $error("divider did not load step count");

endmodule

FILE: rtl/twsa_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twsa_dp
// Datapath: config registers, sample capture, running statistics, window
// RAM, shared divider and output register.
// ----------------------------------------------------------------------------
module twsa_dp
  import twsa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  twsa_cmd_t             cmd,
  output twsa_sts_t             sts,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [OUT_USER_W-1:0] out_tuser
);

  logic signed [TEMP_W-1:0] hi_lim_r, lo_lim_r;
  logic [HUM_W-1:0]         hum_lim_r;

  logic signed [TEMP_W-1:0] t_r;
  logic [HUM_W-1:0]         h_r;

  logic signed [TEMP_W-1:0] min_r, max_r, mean_r, mavg_r;
  logic signed [DIV_W-1:0]  gtot_r;
  logic signed [WSUM_W-1:0] wsum_r, wsum_nxt;
  logic [CNT_W-1:0]         samples_r, alarms_r;
  logic [SLOT_W-1:0]        slot_r;
  logic [FILL_W-1:0]        fill_r;
  logic                     hi_r, lo_r, hh_r;

  logic                     out_valid_r;
  logic [OUT_DATA_W-1:0]    out_data_r;
  logic [OUT_USER_W-1:0]    out_user_r;

  logic [TEMP_W-1:0]        old_raw;
  logic                     full;
  logic                     hi, lo, hh;
  logic signed [DIV_W-1:0]  div_dividend;
  logic [CNT_W-1:0]         div_divisor;
  logic                     div_busy;
  logic signed [TEMP_W-1:0] div_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_lim_r  <= HIGH_RESET;
      lo_lim_r  <= LOW_RESET;
      hum_lim_r <= HUM_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_HIGH_TEMP: hi_lim_r  <= $signed(cfg_data);
        CFG_LOW_TEMP:  lo_lim_r  <= $signed(cfg_data);
        CFG_HUMIDITY:  hum_lim_r <= cfg_data[HUM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      t_r <= $signed(in_tdata[TEMP_W-1:0]);
      h_r <= in_tdata[TEMP_W +: HUM_W];
    end
  end

  twsa_ram #(
    .WIDTH (TEMP_W),
    .DEPTH (WINDOW)
  ) u_win (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (slot_r),
    .wdata (t_r),
    .re    (cmd.capture),
    .raddr (slot_r),
    .rdata (old_raw)
  );

  assign full = fill_r == FILL_W'(WINDOW);
  assign hi   = t_r > hi_lim_r;
  assign lo   = t_r < lo_lim_r;
  assign hh   = h_r > hum_lim_r;

  always_comb begin
    wsum_nxt = wsum_r + WSUM_W'(t_r);
    if (full) begin
      wsum_nxt = wsum_nxt - WSUM_W'($signed(old_raw));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r     <= TEMP_MAX;
      max_r     <= TEMP_MIN;
      gtot_r    <= '0;
      wsum_r    <= '0;
      samples_r <= '0;
      alarms_r  <= '0;
      slot_r    <= '0;
      fill_r    <= '0;
    end else if (cmd.update) begin
      if (samples_r != CNT_SAT) begin
        samples_r <= samples_r + 1'b1;
        gtot_r    <= gtot_r + DIV_W'(t_r);
      end
      if (t_r < min_r) begin
        min_r <= t_r;
      end
      if (t_r > max_r) begin
        max_r <= t_r;
      end
      wsum_r <= wsum_nxt;
      if (!full) begin
        fill_r <= fill_r + 1'b1;
      end
      slot_r <= (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + 1'b1;
      if ((hi || lo || hh) && alarms_r != CNT_SAT) begin
        alarms_r <= alarms_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      hi_r <= hi;
      lo_r <= lo;
      hh_r <= hh;
    end
    if (cmd.store_mean) begin
      mean_r <= div_q;
    end
    if (cmd.store_mavg) begin
      mavg_r <= div_q;
    end
  end

  assign div_dividend = (cmd.div_sel == DIV_SEL_WIN) ? DIV_W'(wsum_r) : gtot_r;
  assign div_divisor  = (cmd.div_sel == DIV_SEL_WIN) ? CNT_W'(fill_r) : samples_r;

  twsa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= {1'b0, alarms_r, samples_r, FILL_OUT_W'(fill_r),
                     mavg_r, mean_r, max_r, min_r};
      out_user_r <= {hh_r, lo_r, hi_r};
    end
  end

  assign sts.div_busy = div_busy;
  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser    = out_user_r;

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(WINDOW))
    else $error("window fill beyond depth");

  a_slot: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r < SLOT_W'(WINDOW) || WINDOW == (1 << SLOT_W))
    else $error("write slot beyond depth");

  a_alarm_le: assert property (@(posedge clk) disable iff (!rst_n)
    alarms_r <= samples_r)
    else $error("alarm count exceeds sample count");

  a_samples_mono: assert property (@(posedge clk) disable iff (!rst_n)
    samples_r >= $past(samples_r))
    else $error("sample count went down");

endmodule

FILE: rtl/twsa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twsa_ctrl
// Sequencer: capture, statistics update, two divider passes, output load.
// ----------------------------------------------------------------------------
module twsa_ctrl
  import twsa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  twsa_sts_t sts,
  output twsa_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_MSTART,
    ST_MWAIT,
    ST_WSTART,
    ST_WWAIT,
    ST_OUT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = ST_MSTART;
      end
      ST_MSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SEL_MEAN;
        state_nxt     = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (!sts.div_busy) begin
          cmd.store_mean = 1'b1;
          state_nxt      = ST_WSTART;
        end
      end
      ST_WSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SEL_WIN;
        state_nxt     = ST_WWAIT;
      end
      ST_WWAIT: begin
        cmd.div_sel = DIV_SEL_WIN;
        if (!sts.div_busy) begin
          cmd.store_mavg = 1'b1;
          state_nxt      = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = state_r == ST_IDLE;

  a_one_phase: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.capture, cmd.update, cmd.div_start, cmd.store_mean,
                cmd.store_mavg, cmd.load_out}) <= 1)
    else $error("overlapping datapath commands");

  a_cap_upd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> cmd.update)
    else $error("capture not followed by update");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_busy |-> !in_tready)
    else $error("input ready while divider runs");

endmodule

FILE: rtl/temp_window_stats_alarm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temp_window_stats_alarm
// Temperature/humidity statistics: min, max, mean, sliding window mean and
// alarm flags with saturating counters.
//
//   Channel  Dir  Handshake           Payload
//   in_      in   tvalid/tready       tdata: temperature, humidity
//   out_     out  tvalid/tready       tdata: stats; tuser: alarm flags
//   cfg_     in   cfg_valid/ready     cfg_index, cfg_data
//
// Each sample runs the shared 48-step restoring divider twice, once for the
// overall mean and once for the window mean.
// rst_n is synchronous, active low; the window RAM is not cleared.
// A result waits in the output register; the next sample is accepted while
// it is stalled. cfg_ready is always high.
// ----------------------------------------------------------------------------
module temp_window_stats_alarm
  import twsa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // temperature[15:0], humidity[29:16], zero[31:30]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // min_temp[15:0], max_temp[31:16], mean_temp[47:32], window_mean[63:48],
  // window_fill[70:64], sample_count[102:71], alarm_count[134:103], zero[135]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // high_temp_alarm[0], low_temp_alarm[1], high_humidity_alarm[2]
  output logic [OUT_USER_W-1:0] out_tuser
);

  twsa_cmd_t cmd;
  twsa_sts_t sts;

  assign cfg_ready = 1'b1;

  twsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  twsa_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
